// ===== rtl/core/dhcpx_pkg.sv =====
package dhcpx_pkg;

  localparam int unsigned NUM_SLOTS        = 4;
  localparam int unsigned MAX_PACKET_BYTES = 2048;
  localparam int unsigned PADDR_W          = 4;
  localparam int unsigned PDATA_W          = 32;

  localparam logic [7:0] OPTIONS_START = 8'd240;
  localparam logic [4:0] ADDR_FIRST    = 5'd16;
  localparam logic [7:0] OPT_PAD       = 8'd0;
  localparam logic [7:0] OPT_END       = 8'd255;

  localparam logic [7:0] CODE_FIRST_RST  = 8'd54;
  localparam logic [7:0] CODE_SECOND_RST = 8'd1;
  localparam logic [7:0] CODE_THIRD_RST  = 8'd3;
  localparam logic [7:0] CODE_FOURTH_RST = 8'd6;

  localparam logic [1:0] REG_CODE_FIRST  = 2'd0;
  localparam logic [1:0] REG_CODE_SECOND = 2'd1;
  localparam logic [1:0] REG_CODE_THIRD  = 2'd2;
  localparam logic [1:0] REG_CODE_FOURTH = 2'd3;

  typedef logic [NUM_SLOTS-1:0][7:0]  code_set_t;
  typedef logic [NUM_SLOTS-1:0][31:0] slot_vals_t;
  typedef logic [NUM_SLOTS-1:0]       slot_mask_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] offered_address;
    logic [31:0] value_first;
    logic [31:0] value_second;
    logic [31:0] value_third;
    logic [31:0] value_fourth;
    logic        found_first;
    logic        found_second;
    logic        found_third;
    logic        found_fourth;
  } out_beat_t;

endpackage

// ===== rtl/core/dhcpx_cfg_regs.sv =====
module dhcpx_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dhcpx_pkg::PADDR_W-1:0] paddr,
  input  logic [dhcpx_pkg::PDATA_W-1:0] pwdata,
  output logic [dhcpx_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  output dhcpx_pkg::code_set_t          codes
);
  import dhcpx_pkg::*;

  code_set_t  codes_r;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign codes   = codes_r;
  assign prdata  = {{(PDATA_W-8){1'b0}}, codes_r[reg_idx]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r[REG_CODE_FIRST]  <= CODE_FIRST_RST;
      codes_r[REG_CODE_SECOND] <= CODE_SECOND_RST;
      codes_r[REG_CODE_THIRD]  <= CODE_THIRD_RST;
      codes_r[REG_CODE_FOURTH] <= CODE_FOURTH_RST;
    end else if (wr_en) begin
      codes_r[reg_idx] <= pwdata[7:0];
    end
  end

endmodule

// ===== rtl/core/dhcpx_parser.sv =====
module dhcpx_parser #(
  parameter int unsigned MAX_PACKET_BYTES = dhcpx_pkg::MAX_PACKET_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dhcpx_pkg::in_beat_t  in_data,
  input  dhcpx_pkg::code_set_t codes,
  input  logic                 out_free,
  output logic                 res_valid,
  output dhcpx_pkg::out_beat_t res_data
);
  import dhcpx_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TYPE,
    PH_LEN,
    PH_VALUE,
    PH_DONE
  } phase_t;

  // input stage
  logic       stage_v_r;
  in_beat_t   stage_data_r;
  logic       adv;
  logic       stage_last;

  // per-packet state
  logic [POS_W-1:0] pos_r, pos_nxt;
  phase_t           phase_r, phase_nxt;
  logic [7:0]       opt_code_r, opt_code_nxt;
  logic [7:0]       vleft_r, vleft_nxt;
  logic [2:0]       vidx_r, vidx_nxt;
  logic [31:0]      addr_r, addr_nxt;
  slot_vals_t       vals_r, vals_nxt;
  slot_mask_t       seen_r, seen_nxt;
  slot_mask_t       nz_r, nz_nxt;
  slot_mask_t       mask_r, mask_nxt;

  logic [7:0] b;
  phase_t     ph;
  slot_mask_t found;

  assign stage_last = stage_data_r.last_byte;
  assign adv        = stage_v_r && (!stage_last || out_free);
  assign in_ready   = !stage_v_r || adv;
  assign res_valid  = adv && stage_last;
  assign b          = stage_data_r.data_byte;

  always_comb begin
    pos_nxt      = pos_r;
    phase_nxt    = phase_r;
    opt_code_nxt = opt_code_r;
    vleft_nxt    = vleft_r;
    vidx_nxt     = vidx_r;
    addr_nxt     = addr_r;
    vals_nxt     = vals_r;
    seen_nxt     = seen_r;
    nz_nxt       = nz_r;
    mask_nxt     = mask_r;
    ph           = phase_r;

    if (pos_r < POS_MAX) begin
      if (pos_r[POS_W-1:2] == (POS_W - 2)'(ADDR_FIRST >> 2)) begin
        addr_nxt = addr_r | ({24'b0, b} << {2'd3 - pos_r[1:0], 3'b000});
      end
      if (phase_r == PH_HEADER && pos_r >= POS_W'(OPTIONS_START)) begin
        ph = PH_TYPE;
      end
      phase_nxt = ph;
      case (ph)
        PH_TYPE: begin
          if (b == OPT_END) begin
            phase_nxt = PH_DONE;
          end else if (b != OPT_PAD) begin
            opt_code_nxt = b;
            phase_nxt    = PH_LEN;
          end
        end
        PH_LEN: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            mask_nxt[i] = !seen_r[i] && (codes[i] == opt_code_r);
            if (mask_nxt[i]) begin
              seen_nxt[i] = 1'b1;
              nz_nxt[i]   = (b != 8'd0);
            end
          end
          if (b == 8'd0) begin
            // nothing to capture, drop the mask
            mask_nxt  = '0;
            phase_nxt = PH_TYPE;
          end else begin
            vleft_nxt = b;
            vidx_nxt  = 3'd0;
            phase_nxt = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (vidx_r < 3'd4) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (mask_r[i]) begin
                vals_nxt[i] = vals_r[i] | ({24'b0, b} << {2'd3 - vidx_r[1:0], 3'b000});
              end
            end
            vidx_nxt = vidx_r + 3'd1;
          end
          vleft_nxt = vleft_r - 8'd1;
          if (vleft_r == 8'd1) begin
            mask_nxt  = '0;
            phase_nxt = PH_TYPE;
          end
        end
        default: begin
        end
      endcase
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  assign found = seen_nxt & nz_nxt;

  always_comb begin
    res_data.offered_address = addr_nxt;
    res_data.value_first     = vals_nxt[0];
    res_data.value_second    = vals_nxt[1];
    res_data.value_third     = vals_nxt[2];
    res_data.value_fourth    = vals_nxt[3];
    res_data.found_first     = found[0];
    res_data.found_second    = found[1];
    res_data.found_third     = found[2];
    res_data.found_fourth    = found[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_ready) begin
      stage_v_r <= in_valid;
    end
    if (in_ready) begin
      stage_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || res_valid) begin
      // start of a new packet
      pos_r      <= '0;
      phase_r    <= PH_HEADER;
      opt_code_r <= '0;
      vleft_r    <= '0;
      vidx_r     <= '0;
      addr_r     <= '0;
      vals_r     <= '0;
      seen_r     <= '0;
      nz_r       <= '0;
      mask_r     <= '0;
    end else if (adv) begin
      pos_r      <= pos_nxt;
      phase_r    <= phase_nxt;
      opt_code_r <= opt_code_nxt;
      vleft_r    <= vleft_nxt;
      vidx_r     <= vidx_nxt;
      addr_r     <= addr_nxt;
      vals_r     <= vals_nxt;
      seen_r     <= seen_nxt;
      nz_r       <= nz_nxt;
      mask_r     <= mask_nxt;
    end
  end

  a_mask_only_in_value: assert property (@(posedge clk) disable iff (!rst_n)
    (mask_r != '0) |-> (phase_r == PH_VALUE))
    else $error("capture mask live outside value phase");

  a_vidx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vidx_r <= 3'd4)
    else $error("value byte index beyond four");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (pos_r == '0 && seen_r == '0 && addr_r == '0))
    else $error("packet state not cleared after final beat");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (stage_v_r && stage_last && !out_free))
    else $error("input stalled without a blocked final beat");

endmodule

// ===== rtl/core/dhcpx_out_stage.sv =====
module dhcpx_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  input  dhcpx_pkg::out_beat_t res_data,
  output logic                 out_free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dhcpx_pkg::out_beat_t out_data
);
  import dhcpx_pkg::*;

  logic      out_valid_r;
  out_beat_t out_data_r;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_valid;
    end
    if (out_free && res_valid) begin
      out_data_r <= res_data;
    end
  end

endmodule

// ===== rtl/core/dhcp_reply_option_extractor.sv =====
// DHCP/BOOTP reply option extractor. Feed one packet byte per in_ beat with
// last_byte set on the final one; a single result beat follows for each
// packet, carrying the offered address (bytes 16 to 19) and, for the four
// option codes held in the configuration registers, the first four value
// bytes of each code's first occurrence plus a found flag. One byte is taken
// every cycle unless the input stalls: a byte passes an input register, one
// short parse step and, on the final byte, the result register that drives
// out_valid. Input stalls only while a final byte waits behind an unaccepted
// result. Bytes at or beyond MAX_PACKET_BYTES are skipped.
// Write the option codes only while no packet is in flight.
module dhcp_reply_option_extractor #(
  parameter int unsigned MAX_PACKET_BYTES = dhcpx_pkg::MAX_PACKET_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dhcpx_pkg::in_beat_t           in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dhcpx_pkg::out_beat_t          out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dhcpx_pkg::PADDR_W-1:0] paddr,
  input  logic [dhcpx_pkg::PDATA_W-1:0] pwdata,
  output logic [dhcpx_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);
  import dhcpx_pkg::*;

  code_set_t codes;
  logic      out_free;
  logic      res_valid;
  out_beat_t res_data;

  dhcpx_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .codes   (codes)
  );

  dhcpx_parser #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .codes     (codes),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  dhcpx_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_data  (res_data),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/dhcp_reply_checker.sv =====
`timescale 1ns / 100ps

module dhcp_reply_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  dhcpx_pkg::in_beat_t           in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  dhcpx_pkg::out_beat_t          out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dhcpx_pkg::PADDR_W-1:0] paddr,
  input  logic [dhcpx_pkg::PDATA_W-1:0] pwdata,
  input  logic                          pready,
  output int unsigned                   failures,
  output int unsigned                   outstanding
);
  import dhcpx_pkg::*;

  typedef enum logic [2:0] {
    WALK_HEADER,
    WALK_TYPE,
    WALK_LEN,
    WALK_VALUE,
    WALK_DONE
  } walk_phase_t;

  code_set_t   codes;
  logic [15:0] byte_pos;
  walk_phase_t phase;
  logic [7:0]  opt_code;
  logic [7:0]  value_left;
  logic [7:0]  value_idx;
  logic [31:0] offered;
  slot_vals_t  slot_val;
  slot_mask_t  slot_seen;
  slot_mask_t  slot_nonzero;
  slot_mask_t  capturing;

  out_beat_t   expected_replies[$];
  out_beat_t   want_reply;
  int unsigned reply_count;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    failures++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("reply %0d %s: got %h, want %h",
                                reply_count, name, got, want));
    end
  endtask

  task automatic clear_packet();
    byte_pos     = '0;
    phase        = WALK_HEADER;
    opt_code     = '0;
    value_left   = '0;
    value_idx    = '0;
    offered      = '0;
    slot_val     = '0;
    slot_seen    = '0;
    slot_nonzero = '0;
    capturing    = '0;
  endtask

  // Advance the option walk by one packet byte at byte_pos.
  task automatic absorb_byte(input logic [7:0] b);
    int unsigned sh;
    int          i;
    if (byte_pos >= ADDR_FIRST && byte_pos <= ADDR_FIRST + 3) begin
      sh      = 8 * (ADDR_FIRST + 3 - byte_pos);
      offered = offered | ({24'd0, b} << sh);
    end
    if (phase == WALK_HEADER && byte_pos >= OPTIONS_START) phase = WALK_TYPE;
    case (phase)
      WALK_TYPE: begin
        if (b == OPT_END) begin
          phase = WALK_DONE;
        end else if (b != OPT_PAD) begin
          opt_code = b;
          phase    = WALK_LEN;
        end
      end
      WALK_LEN: begin
        // only the first occurrence of a code claims its slot
        capturing = '0;
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (!slot_seen[i] && codes[i] == opt_code) begin
            slot_seen[i]    = 1'b1;
            slot_nonzero[i] = (b != 8'd0);
            capturing[i]    = 1'b1;
          end
        end
        if (b == 8'd0) begin
          phase = WALK_TYPE;
        end else begin
          value_left = b;
          value_idx  = '0;
          phase      = WALK_VALUE;
        end
      end
      WALK_VALUE: begin
        if (value_idx < 4) begin
          sh = 8 * (3 - value_idx);
          for (i = 0; i < NUM_SLOTS; i++) begin
            if (capturing[i]) slot_val[i] = slot_val[i] | ({24'd0, b} << sh);
          end
          value_idx++;
        end
        value_left--;
        if (value_left == 8'd0) begin
          capturing = '0;
          phase     = WALK_TYPE;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      codes = {CODE_FOURTH_RST, CODE_THIRD_RST, CODE_SECOND_RST, CODE_FIRST_RST};
      clear_packet();
      expected_replies.delete();
      failures    = 0;
      reply_count = 0;
    end else begin
      // compare first: a reply never belongs to a final byte taken at this edge
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("reply %0d arrived with none expected", reply_count));
        end else begin
          want_reply = expected_replies.pop_front();
          check_field("offered_address", out_data.offered_address,
                      want_reply.offered_address);
          check_field("value_first", out_data.value_first, want_reply.value_first);
          check_field("value_second", out_data.value_second, want_reply.value_second);
          check_field("value_third", out_data.value_third, want_reply.value_third);
          check_field("value_fourth", out_data.value_fourth, want_reply.value_fourth);
          check_field("found_first", 32'(out_data.found_first),
                      32'(want_reply.found_first));
          check_field("found_second", 32'(out_data.found_second),
                      32'(want_reply.found_second));
          check_field("found_third", 32'(out_data.found_third),
                      32'(want_reply.found_third));
          check_field("found_fourth", 32'(out_data.found_fourth),
                      32'(want_reply.found_fourth));
        end
        reply_count++;
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_CODE_FIRST:  codes[0] = pwdata[7:0];
          REG_CODE_SECOND: codes[1] = pwdata[7:0];
          REG_CODE_THIRD:  codes[2] = pwdata[7:0];
          REG_CODE_FOURTH: codes[3] = pwdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (byte_pos < MAX_PACKET_BYTES) absorb_byte(in_data.data_byte);
        if (byte_pos != 16'hffff) byte_pos++;
        if (in_data.last_byte) begin
          want_reply.offered_address = offered;
          want_reply.value_first     = slot_val[0];
          want_reply.value_second    = slot_val[1];
          want_reply.value_third     = slot_val[2];
          want_reply.value_fourth    = slot_val[3];
          want_reply.found_first     = slot_seen[0] & slot_nonzero[0];
          want_reply.found_second    = slot_seen[1] & slot_nonzero[1];
          want_reply.found_third     = slot_seen[2] & slot_nonzero[2];
          want_reply.found_fourth    = slot_seen[3] & slot_nonzero[3];
          expected_replies.push_back(want_reply);
          clear_packet();
        end
      end
    end
    outstanding = expected_replies.size();
  end

endmodule

// ===== tb/dhcp_reply_option_extractor_tb.sv =====
`timescale 1ns / 100ps

module dhcp_reply_option_extractor_tb;
  import dhcpx_pkg::*;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned LONG_HOLD   = 300;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_beat_t           in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_beat_t          out_data;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [PDATA_W-1:0] pwdata    = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int unsigned failures;
  int unsigned outstanding;

  logic        calm        = 1'b0;
  int unsigned hold_asked  = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;

  logic [7:0]  pkt[$];
  logic [7:0]  codes_now[4];
  int unsigned rand_bytes   = 0;
  int unsigned rand_packets = 0;
  int unsigned phase_no     = 0;

  always #5 clk = ~clk;

  dhcp_reply_option_extractor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  dhcp_reply_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .failures    (failures),
    .outstanding (outstanding)
  );

  // Result side: random stalls, or a long hold when the stimulus asks for one.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      out_ready   <= 1'b0;
      hold_served <= hold_served + 1;
      hold_left   <= LONG_HOLD - 1;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 9);
    end
  end

  initial begin
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("[dhcp_reply_option_extractor] ERROR");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {b, l};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_packet();
    int unsigned k;
    for (k = 0; k < pkt.size(); k++) send_byte(pkt[k], k == pkt.size() - 1);
  endtask

  task automatic start_header(input logic [31:0] addr);
    int unsigned k;
    pkt.delete();
    for (k = 0; k < OPTIONS_START; k++) pkt.push_back(8'($urandom_range(255)));
    pkt[16] = addr[31:24];
    pkt[17] = addr[23:16];
    pkt[18] = addr[15:8];
    pkt[19] = addr[7:0];
  endtask

  task automatic add_option(input logic [7:0] code, input int unsigned len);
    pkt.push_back(code);
    pkt.push_back(8'(len));
    repeat (len) pkt.push_back(8'($urandom_range(255)));
  endtask

  task automatic push_bytes(input logic [7:0] a, input logic [7:0] b,
                            input logic [7:0] c, input logic [7:0] d);
    pkt.push_back(a);
    pkt.push_back(b);
    pkt.push_back(c);
    pkt.push_back(d);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_codes(input logic [7:0] c0, input logic [7:0] c1,
                           input logic [7:0] c2, input logic [7:0] c3);
    codes_now[0] = c0;
    codes_now[1] = c1;
    codes_now[2] = c2;
    codes_now[3] = c3;
    write_reg(REG_CODE_FIRST, c0);
    write_reg(REG_CODE_SECOND, c1);
    write_reg(REG_CODE_THIRD, c2);
    write_reg(REG_CODE_FOURTH, c3);
  endtask

  // Hold the input until every reply is back, then let the pipeline settle.
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_packet();
    int unsigned n_opts, k, len, cut, pick;
    logic [7:0]  code;
    pick = $urandom_range(99);
    pkt.delete();
    if (pick < 8) begin
      len = ($urandom_range(1) != 0) ? $urandom_range(1, 24) : $urandom_range(25, 239);
      repeat (len) pkt.push_back(8'($urandom_range(255)));
    end else begin
      start_header($urandom);
      n_opts = $urandom_range(0, 10);
      for (k = 0; k < n_opts; k++) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          pkt.push_back(OPT_PAD);
        end else begin
          if (pick < 65) code = codes_now[$urandom_range(3)];
          else code = 8'($urandom_range(255));
          pick = $urandom_range(99);
          if (pick < 12) len = 0;
          else if (pick < 60) len = $urandom_range(1, 4);
          else if (pick < 97) len = $urandom_range(5, 24);
          else len = 255;
          add_option(code, len);
        end
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        pkt.push_back(OPT_END);
        repeat ($urandom_range(0, 6)) pkt.push_back(8'($urandom_range(255)));
      end else if (pick >= 80 && pkt.size() > 241) begin
        // break off mid-option
        cut = $urandom_range(241, pkt.size() - 1);
        while (pkt.size() > cut) pkt.pop_back();
      end
    end
  endtask

  initial begin
    int unsigned k;
    codes_now[0] = CODE_FIRST_RST;
    codes_now[1] = CODE_SECOND_RST;
    codes_now[2] = CODE_THIRD_RST;
    codes_now[3] = CODE_FOURTH_RST;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // one-byte packet
    pkt.delete();
    pkt.push_back(8'hff);
    send_packet();

    // packet ends inside the offered address
    pkt.delete();
    repeat (18) pkt.push_back(8'($urandom_range(255)));
    send_packet();

    // default codes, short and long values, pad, duplicate, end and junk
    start_header(32'hdeadbeef);
    add_option(8'd53, 1);
    push_bytes(8'd54, 8'd4, 8'hc0, 8'ha8);
    push_bytes(8'h01, 8'h01, 8'd1, 8'd4);
    push_bytes(8'hff, 8'hff, 8'hff, 8'h00);
    pkt.push_back(OPT_PAD);
    add_option(8'd3, 8);
    push_bytes(8'd6, 8'd2, 8'h08, 8'h08);
    add_option(8'd54, 4);
    pkt.push_back(OPT_END);
    repeat (5) pkt.push_back(8'($urandom_range(255)));
    send_packet();

    // zero length claims the slot; final byte is an option type with no length
    start_header(32'h0);
    pkt.push_back(8'd1);
    pkt.push_back(8'd0);
    add_option(8'd1, 4);
    add_option(8'd3, 4);
    pkt.push_back(8'd54);
    send_packet();

    // one code in two slots, an unmatchable code, packet ends inside a value
    drain_replies();
    set_codes(8'd54, 8'd0, 8'd200, 8'd54);
    start_header($urandom);
    pkt.push_back(OPT_PAD);
    add_option(8'd54, 6);
    add_option(8'd0, 2);
    push_bytes(8'd200, 8'd3, 8'haa, 8'hbb);
    send_packet();

    // hold the result side while tiny packets keep coming, so the input stalls
    drain_replies();
    set_codes(CODE_FIRST_RST, CODE_SECOND_RST, CODE_THIRD_RST, CODE_FOURTH_RST);
    hold_asked <= hold_asked + 1;
    repeat (24) begin
      pkt.delete();
      repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom_range(255)));
      send_packet();
    end

    while (rand_packets < 3 || rand_bytes < 500) begin
      drain_replies();
      for (k = 0; k < NUM_SLOTS; k++) begin
        case ($urandom_range(9))
          0:       codes_now[k] = 8'd0;
          1:       codes_now[k] = 8'd255;
          2:       codes_now[k] = (k > 0) ? codes_now[k-1] : 8'd54;
          default: codes_now[k] = 8'($urandom_range(1, 254));
        endcase
      end
      set_codes(codes_now[0], codes_now[1], codes_now[2], codes_now[3]);
      calm <= (phase_no == 1);
      random_packet();
      rand_bytes   += pkt.size();
      rand_packets += 1;
      send_packet();
      phase_no++;
    end

    drain_replies();
    repeat (8) @(negedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("[dhcp_reply_option_extractor] OK");
    end else begin
      $display("[dhcp_reply_option_extractor] ERROR");
    end
    $finish;
  end

endmodule
